### hdl/gda_pkg.sv
// Package for the geofence distance alert block.
// Shared widths, constants, the CORDIC arctangent table and the sideband record type.
// No dependencies.
package gda_pkg;

  localparam int LatW   = 28;
  localparam int LonW   = 29;
  localparam int TimeW  = 32;
  localparam int DistW  = 25;
  localparam int RadW   = 15;
  localparam int StillW = 16;
  localparam int CfgW   = 29;
  localparam int CfgAw  = 2;

  // register indexes
  localparam logic [CfgAw-1:0] REG_STATION_LAT = 2'd0;
  localparam logic [CfgAw-1:0] REG_STATION_LON = 2'd1;
  localparam logic [CfgAw-1:0] REG_ALERT_RAD   = 2'd2;
  localparam logic [CfgAw-1:0] REG_STILL_SEC   = 2'd3;

  // microdegrees to binary angle, 2^60/360e6
  localparam logic [31:0] UdegToBam    = 32'd3202559735;
  localparam logic [31:0] CordicGainInv = 32'd652032874;
  localparam logic [30:0] DistScale    = 31'd1279768231;
  localparam logic [30:0] Q30One       = 31'h4000_0000;

  // CORDIC datapath width: Q30 plus headroom
  localparam int CW = 34;

  function automatic logic [CW-1:0] atan_entry(input int i);
    logic [CW-1:0] t;
    t = '0;
    case (i)
      0: t = 34'd536870912;  1: t = 34'd316933406;  2: t = 34'd167458907;
      3: t = 34'd85004756;   4: t = 34'd42667331;   5: t = 34'd21354465;
      6: t = 34'd10679838;   7: t = 34'd5340245;    8: t = 34'd2670163;
      9: t = 34'd1335087;   10: t = 34'd667544;    11: t = 34'd333772;
      12: t = 34'd166886;   13: t = 34'd83443;     14: t = 34'd41722;
      15: t = 34'd20861;    16: t = 34'd10430;     17: t = 34'd5215;
      18: t = 34'd2608;     19: t = 34'd1304;      20: t = 34'd652;
      21: t = 34'd326;      22: t = 34'd163;       23: t = 34'd81;
      24: t = 34'd41;       25: t = 34'd20;        26: t = 34'd10;
      27: t = 34'd5;        28: t = 34'd3;         29: t = 34'd1;
      30: t = 34'd1;
      default: t = '0;
    endcase
    return t;
  endfunction

  // sideband that rides along the pipeline
  typedef struct packed {
    logic [TimeW-1:0]  age;
    logic [RadW-1:0]   rad;
    logic [StillW-1:0] still;
  } side_t;

endpackage

### hdl/geofence_distance_alert.sv
// Top level of the geofence distance alert: angle conversion, haversine term,
// CORDIC sin/cos, square roots, CORDIC atan, scaling and the alert compare.
// Depends on gda_pkg, gda_sincos, gda_isqrt, gda_atan.
//
//  channel | direction | contents
//  in_*    | slave     | tdata: sonde_lat[27:0], sonde_lon[56:28], report_time[88:57],
//          |           |        now_time[120:89]
//  out_*   | master    | tdata: distance_m[24:0], age_seconds[56:25], alert[57]
//  cfg_*   | write     | index 0..3: station_lat, station_lon, alert_radius_km, still_seconds
//
// One report per cycle while the output is not stalled. The sin/cos CORDIC,
// square root and atan CORDIC chains lie in series.
// The whole pipeline advances only when the output register is free or taken,
// so a stall freezes every stage and nothing is lost or repeated.
// Reset (rst_n, synchronous) clears the valid bits and loads register defaults.
module geofence_distance_alert
  import gda_pkg::*;
#(
  parameter int CORDIC_STAGES = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [127:0]      in_tdata,   // sonde_lat, sonde_lon, report_time, now_time
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       out_tdata,  // distance_m, age_seconds, alert
  input  logic              cfg_we,
  input  logic [CfgAw-1:0]  cfg_index,
  input  logic [CfgW-1:0]   cfg_wdata
);

  localparam int N   = CORDIC_STAGES;
  localparam int LAT = 2 * N + 40;  // stages carrying valid

  // configuration registers
  logic [LatW-1:0]   st_lat_r;
  logic [LonW-1:0]   st_lon_r;
  logic [RadW-1:0]   rad_r;
  logic [StillW-1:0] still_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_lat_r <= LatW'(50000000);
      st_lon_r <= LonW'(20000000);
      rad_r    <= RadW'(15);
      still_r  <= StillW'(150);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STATION_LAT: st_lat_r <= cfg_wdata[LatW-1:0];
        REG_STATION_LON: st_lon_r <= cfg_wdata[LonW-1:0];
        REG_ALERT_RAD:   rad_r    <= cfg_wdata[RadW-1:0];
        REG_STILL_SEC:   still_r  <= cfg_wdata[StillW-1:0];
        default: ;
      endcase
    end
  end

  // global advance
  logic en;
  logic [LAT-1:0] vld_r;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[LAT-2:0], in_tvalid};
  end

  // sideband delay line
  side_t side_r [0:LAT-1];
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= '{age: in_tdata[120:89] - in_tdata[88:57], rad: rad_r, still: still_r};
      for (int k = 1; k < LAT; k++) side_r[k] <= side_r[k-1];
    end
  end

  // stage 1: microdegree times scale, per coordinate
  logic signed [63:0] p_r [0:3];
  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= 64'(signed'(st_lat_r)) * signed'({32'd0, UdegToBam});
      p_r[1] <= 64'(signed'(st_lon_r)) * signed'({32'd0, UdegToBam});
      p_r[2] <= 64'(signed'(in_tdata[27:0])) * signed'({32'd0, UdegToBam});
      p_r[3] <= 64'(signed'(in_tdata[56:28])) * signed'({32'd0, UdegToBam});
    end
  end

  // stage 2: round to 36-bit angle, form half differences
  logic [35:0] b [0:3];
  always_comb begin
    for (int k = 0; k < 4; k++) b[k] = 36'((p_r[k] + 64'(1 << 27)) >>> 28);
  end

  logic [31:0] hlat_r, hlon_r, lat1_r, lat2_r;
  logic [32:0] dlat, dlon;
  assign dlat = 33'(b[2] - b[0]);
  assign dlon = 33'(b[3] - b[1]);
  always_ff @(posedge clk) begin
    if (en) begin
      hlat_r <= dlat[32:1];
      hlon_r <= dlon[32:1];
      lat1_r <= b[0][31:0];
      lat2_r <= b[2][31:0];
    end
  end

  // four sin/cos units in parallel, N+1 stages
  logic signed [CW-1:0] s1, s2, c1, c2, u0, u1, u2, u3;
  gda_sincos #(.CORDIC_STAGES(N)) u_sc0 (.clk, .en, .ang(hlat_r), .sin_o(s1), .cos_o(u0));
  gda_sincos #(.CORDIC_STAGES(N)) u_sc1 (.clk, .en, .ang(hlon_r), .sin_o(s2), .cos_o(u1));
  gda_sincos #(.CORDIC_STAGES(N)) u_sc2 (.clk, .en, .ang(lat1_r), .sin_o(u2), .cos_o(c1));
  gda_sincos #(.CORDIC_STAGES(N)) u_sc3 (.clk, .en, .ang(lat2_r), .sin_o(u3), .cos_o(c2));

  // products: squares and cos product, then the combined term
  logic signed [CW-1:0] sq1_r, sq2_r, cc_r;
  logic signed [67:0]   m1, m2, m3;
  assign m1 = 68'(s1) * 68'(s1);
  assign m2 = 68'(s2) * 68'(s2);
  assign m3 = 68'(c1) * 68'(c2);
  always_ff @(posedge clk) begin
    if (en) begin
      sq1_r <= CW'(m1 >>> 30);
      sq2_r <= CW'(m2 >>> 30);
      cc_r  <= CW'(m3 >>> 30);
    end
  end

  logic signed [CW-1:0] t2_r, sq1d_r;
  logic signed [67:0]   m4;
  assign m4 = 68'(cc_r) * 68'(sq2_r);
  always_ff @(posedge clk) begin
    if (en) begin
      t2_r   <= CW'(m4 >>> 30);
      sq1d_r <= sq1_r;
    end
  end

  // clamp a to [0, 1]
  logic signed [CW:0] asum;
  logic [30:0]        a_r;
  assign asum = (CW+1)'(sq1d_r) + (CW+1)'(t2_r);
  always_ff @(posedge clk) begin
    if (en) begin
      if (asum[CW])                                  a_r <= '0;
      else if (asum > (CW+1)'(signed'({1'b0, Q30One}))) a_r <= Q30One;
      else                                           a_r <= asum[30:0];
    end
  end

  // square roots of a and 1-a
  logic [30:0] ra, rb, oma;
  assign oma = Q30One - a_r;
  gda_isqrt u_sqa (.clk, .en, .v({a_r, 31'd0} >> 1), .root(ra));
  gda_isqrt u_sqb (.clk, .en, .v({oma, 31'd0} >> 1), .root(rb));

  // arctangent
  logic [30:0] z;
  gda_atan #(.CORDIC_STAGES(N)) u_at (.clk, .en, .xin(rb), .yin(ra), .z_o(z));

  // scale to metres
  logic [61:0] dprod_r;
  always_ff @(posedge clk) begin
    if (en) dprod_r <= {31'd0, z} * {31'd0, DistScale};
  end

  logic [DistW-1:0] dist_m;
  logic [62:0]      drnd;
  logic [25:0]      limit;
  side_t            sd;
  assign drnd   = {1'b0, dprod_r} + (63'd1 << 35);
  assign dist_m = drnd[60:36];
  assign sd     = side_r[LAT-1];
  assign limit  = 26'(sd.rad * 26'd1000);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (en) out_tvalid <= vld_r[LAT-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata <= {6'd0,
                    ({1'b0, dist_m} < limit) && (sd.age > {16'd0, sd.still}),
                    sd.age, dist_m};
    end
  end

  // checks
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while pipeline frozen");
  a_alert: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[57] |-> out_tdata[56:25] != 32'd0)
    else $error("alert with zero age");

endmodule

### hdl/gda_sincos.sv
// Pipelined CORDIC rotation: sine and cosine of a 32-bit binary angle, Q30.
// One register stage per CORDIC step plus one for the quadrant fold.
// Depends on gda_pkg.
module gda_sincos
  import gda_pkg::*;
#(
  parameter int CORDIC_STAGES = 24
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [31:0]          ang,
  output logic signed [CW-1:0] sin_o,
  output logic signed [CW-1:0] cos_o
);

  localparam int N = CORDIC_STAGES;

  logic signed [CW-1:0] x_r [0:N];
  logic signed [CW-1:0] y_r [0:N];
  logic signed [CW-1:0] z_r [0:N];
  logic                 f_r [0:N];

  // fold angle into [-quarter, quarter)
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CW'(signed'({1'b0, CordicGainInv}));
      y_r[0] <= '0;
      case (ang[31:30])
        2'd0: begin z_r[0] <= CW'(signed'({1'b0, ang}));      f_r[0] <= 1'b0; end
        2'd3: begin z_r[0] <= CW'(signed'({2'b11, ang}));     f_r[0] <= 1'b0; end
        default: begin
          z_r[0] <= CW'(signed'({1'b0, ang})) - (CW'(1) <<< 31);
          f_r[0] <= 1'b1;
        end
      endcase
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        f_r[i+1] <= f_r[i];
        if (!z_r[i][CW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_entry(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_entry(i);
        end
      end
    end
  end

  assign sin_o = f_r[N] ? -y_r[N] : y_r[N];
  assign cos_o = f_r[N] ? -x_r[N] : x_r[N];

endmodule

### hdl/gda_isqrt.sv
// Pipelined integer square root of a 62-bit value by trial squaring, one result bit per stage.
// 32 register stages (input register plus one per root bit); floor result.
// Depends on gda_pkg.
module gda_isqrt
  import gda_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [61:0] v,
  output logic [30:0] root
);

  localparam int NB = 31;

  logic [61:0] rem_r [0:NB];
  logic [30:0] q_r   [0:NB];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= v;
      q_r[0]   <= '0;
    end
  end

  // bit k of the root decided at stage NB-1-k
  for (genvar s = 0; s < NB; s++) begin : g_bit
    localparam int K = NB - 1 - s;
    logic [61:0] trial;
    logic [30:0] qt;
    always_comb begin
      qt    = q_r[s] | (31'd1 << K);
      trial = ({31'd0, qt} * {31'd0, qt});
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= rem_r[s];
        q_r[s+1]   <= (trial <= rem_r[s]) ? qt : q_r[s];
      end
    end
  end

  assign root = q_r[NB];

endmodule

### hdl/gda_atan.sv
// Pipelined CORDIC vectoring: atan2(y, x) as a binary angle, one step per stage.
// Output is clamped to [0, 2^30].
// Depends on gda_pkg.
module gda_atan
  import gda_pkg::*;
#(
  parameter int CORDIC_STAGES = 24
) (
  input  logic        clk,
  input  logic        en,
  input  logic [30:0] xin,
  input  logic [30:0] yin,
  output logic [30:0] z_o
);

  localparam int N = CORDIC_STAGES;

  logic signed [CW-1:0] x_r [0:N];
  logic signed [CW-1:0] y_r [0:N];
  logic signed [CW-1:0] z_r [0:N];

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CW'(signed'({1'b0, xin}));
      y_r[0] <= CW'(signed'({1'b0, yin}));
      z_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_entry(i);
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_entry(i);
        end
      end
    end
  end

  // clamp
  always_comb begin
    if (z_r[N][CW-1])                     z_o = '0;
    else if (z_r[N] > CW'(signed'({1'b0, Q30One}))) z_o = Q30One;
    else                                  z_o = z_r[N][30:0];
  end

endmodule
